/* hw/rtl/mlfq_pkg.sv */
// Shared types and constants for the feedback-queue thread scheduler.
package mlfq_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_W        = 4;
    localparam int CNT_W       = 5;
    localparam int NUM_Q       = 3;
    localparam int MEM_DEPTH   = NUM_Q * MAX_THREADS;
    localparam int MEM_AW      = 6;

    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_YIELD  = 3'd1;
    localparam logic [2:0] ST_WAIT_M = 3'd2;
    localparam logic [2:0] ST_WAIT_T = 3'd3;
    localparam logic [2:0] ST_EXIT   = 3'd4;

    localparam logic [2:0] REQ_TIMER  = 3'd0;
    localparam logic [2:0] REQ_YIELD  = 3'd1;
    localparam logic [2:0] REQ_CREATE = 3'd2;
    localparam logic [2:0] REQ_EXIT   = 3'd3;
    localparam logic [2:0] REQ_JOIN   = 3'd4;

    localparam logic [1:0] CFG_QUANTUM1 = 2'd0;
    localparam logic [1:0] CFG_QUANTUM2 = 2'd1;
    localparam logic [1:0] CFG_QUANTUM3 = 2'd2;
    localparam logic [1:0] CFG_PERIOD   = 2'd3;

    localparam logic [1:0] Q1 = 2'd0;
    localparam logic [1:0] Q2 = 2'd1;
    localparam logic [1:0] Q3 = 2'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] target_id;
    } in_t;

    typedef struct packed {
        logic [3:0]  running_id;
        logic [15:0] quantum;
        logic [3:0]  new_id;
        logic        join_done;
        logic        switched;
        logic        error;
    } out_t;

    // handshake between the request queue and the sequencer
    typedef struct packed {
        logic valid;
        in_t  item;
    } req_ch_t;

    // level to queue: level one and two map directly, anything else is level three
    function automatic logic [1:0] level_queue(input logic [1:0] lv);
        case (lv)
            2'd1:    level_queue = Q1;
            2'd2:    level_queue = Q2;
            default: level_queue = Q3;
        endcase
    endfunction

endpackage

/* hw/rtl/mlfq_front.sv */
// Request front end: two-entry item queue ahead of the sequencer.
module mlfq_front import mlfq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  in_t     in_item,
    output req_ch_t req,
    input  logic    req_pop
);

    in_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = req_pop && (cnt_reg != 2'd0);

    assign req.valid = (cnt_reg != 2'd0);
    assign req.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hw/rtl/mlfq_engine.sv */
// Scheduling sequencer: ready queues, thread tables and result register.
module mlfq_engine import mlfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_ch_t     req,
    output logic        req_pop,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_item
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_CR_CUR  = 12'b0000_0000_0010,
        S_CR_NEW  = 12'b0000_0000_0100,
        S_CR_MARK = 12'b0000_0000_1000,
        S_SC_START= 12'b0000_0001_0000,
        S_SC_READ = 12'b0000_0010_0000,
        S_SC_EVAL = 12'b0000_0100_0000,
        S_APPLY   = 12'b0000_1000_0000,
        S_MAINT   = 12'b0001_0000_0000,
        S_PROMOTE = 12'b0010_0000_0000,
        S_FINISH  = 12'b0100_0000_0000,
        S_OUT     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] q1_reg, q2_reg, q3_reg;
    logic [7:0]  period_reg;

    logic [ID_W-1:0]  fifo_mem [MEM_DEPTH];
    logic [ID_W-1:0]  rd_reg;
    logic [ID_W-1:0]  head_reg  [NUM_Q];
    logic [CNT_W-1:0] count_reg [NUM_Q];

    logic [2:0]      status_reg [MAX_THREADS];
    logic [1:0]      level_reg  [MAX_THREADS];
    logic [ID_W-1:0] wait_reg   [MAX_THREADS];
    logic [MAX_THREADS-1:0] done_reg;

    logic [ID_W-1:0]  cur_reg, next_reg;
    logic             has_reg;
    logic [CNT_W-1:0] nfid_reg;
    logic [7:0]       mc_reg;
    logic [1:0]       qsel_reg;
    logic [CNT_W-1:0] n_reg, i_reg;
    out_t             res_reg;
    logic             out_valid_reg;
    out_t             out_reg;

    // memory controls
    logic              push_en, pop_en;
    logic [1:0]        push_q, pop_q;
    logic [ID_W-1:0]   push_id;
    logic [MEM_AW-1:0] waddr, raddr;
    logic              mem_we;

    // table reads
    logic [ID_W-1:0] st_ra, lv_ra;
    logic [2:0]      st_rd;
    logic [1:0]      lv_rd;
    logic [2:0]      st_cur;
    logic [ID_W-1:0] w_t;
    logic            done_w, eval_pick, eval_push;
    logic [5:0]      id_need;
    logic            cr_err;
    logic            last_in_q, promo_any;
    logic [1:0]      promo_q;
    logic            out_free;

    assign st_ra  = (state_reg == S_SC_EVAL) ? rd_reg : cur_reg;
    assign lv_ra  = (state_reg == S_FINISH) ? next_reg : cur_reg;
    assign st_rd  = status_reg[st_ra];
    assign lv_rd  = level_reg[lv_ra];
    assign st_cur = st_rd;
    assign w_t    = wait_reg[rd_reg];
    assign done_w = done_reg[w_t];

    assign eval_pick = (st_rd == ST_RUN) || (st_rd == ST_WAIT_M)
                    || ((st_rd == ST_WAIT_T) && done_w);
    assign eval_push = (st_rd == ST_WAIT_T) && !done_w;

    assign id_need = {1'b0, nfid_reg} + (has_reg ? 6'd1 : 6'd2);
    assign cr_err  = (id_need > 6'(MAX_THREADS)) || count_reg[Q1][CNT_W-1];

    assign last_in_q = ((i_reg + 5'd1) == n_reg);
    assign promo_any = (count_reg[Q3] != '0) || (count_reg[Q2] != '0);
    assign promo_q   = (count_reg[Q3] != '0) ? Q3 : Q2;

    assign out_free  = !out_valid_reg || !out_stall;
    assign req_pop   = (state_reg == S_IDLE) && req.valid;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        push_en = 1'b0;
        push_q  = Q1;
        push_id = nfid_reg[ID_W-1:0];
        pop_en  = 1'b0;
        pop_q   = qsel_reg;
        case (state_reg)
            S_CR_NEW:
            begin
                push_en = 1'b1;
            end
            S_SC_READ:
            begin
                pop_en = 1'b1;
            end
            S_SC_EVAL:
            begin
                push_en = eval_push;
                push_q  = qsel_reg;
                push_id = rd_reg;
            end
            S_APPLY:
            begin
                push_id = cur_reg;
                case (st_cur)
                    ST_RUN:
                    begin
                        push_en = 1'b1;
                        push_q  = (lv_rd == 2'd1) ? Q2 : Q3;
                    end
                    ST_YIELD, ST_WAIT_M, ST_WAIT_T:
                    begin
                        push_en = 1'b1;
                        push_q  = level_queue(lv_rd);
                    end
                    default: push_en = 1'b0;
                endcase
            end
            S_MAINT:
            begin
                pop_en = (mc_reg >= period_reg) && promo_any;
                pop_q  = promo_q;
            end
            S_PROMOTE:
            begin
                push_en = 1'b1;
                push_id = rd_reg;
            end
            default: push_en = 1'b0;
        endcase
        // a full queue drops the push
        mem_we = push_en && !count_reg[push_q][CNT_W-1];
        waddr  = {push_q, head_reg[push_q] + count_reg[push_q][ID_W-1:0]};
        raddr  = {pop_q, head_reg[pop_q]};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fifo_mem[waddr] <= push_id;
        end
        if (pop_en)
        begin
            rd_reg <= fifo_mem[raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.item.req_type == REQ_CREATE)
                    begin
                        state_next = cr_err ? S_OUT : (has_reg ? S_CR_NEW : S_CR_CUR);
                    end
                    else if (!has_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        case (req.item.req_type)
                            REQ_TIMER, REQ_YIELD, REQ_EXIT: state_next = S_SC_START;
                            REQ_JOIN:
                                state_next = done_reg[req.item.target_id] ? S_OUT : S_SC_START;
                            default: state_next = S_OUT;
                        endcase
                    end
                end
            end
            S_CR_CUR:   state_next = S_CR_NEW;
            S_CR_NEW:   state_next = S_CR_MARK;
            S_CR_MARK:  state_next = S_SC_START;
            S_SC_START:
            begin
                if (count_reg[qsel_reg] != '0)
                begin
                    state_next = S_SC_READ;
                end
                else if (qsel_reg == Q3)
                begin
                    state_next = S_OUT;
                end
            end
            S_SC_READ:  state_next = S_SC_EVAL;
            S_SC_EVAL:
            begin
                if (eval_pick)
                begin
                    state_next = S_APPLY;
                end
                else if (!last_in_q)
                begin
                    state_next = S_SC_READ;
                end
                else
                begin
                    state_next = (qsel_reg == Q3) ? S_OUT : S_SC_START;
                end
            end
            S_APPLY:    state_next = S_MAINT;
            S_MAINT:    state_next = pop_en ? S_PROMOTE : S_FINISH;
            S_PROMOTE:  state_next = S_FINISH;
            S_FINISH:   state_next = S_OUT;
            S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            q1_reg        <= 16'd10;
            q2_reg        <= 16'd20;
            q3_reg        <= 16'd40;
            period_reg    <= 8'd10;
            done_reg      <= '0;
            cur_reg       <= '0;
            has_reg       <= 1'b0;
            nfid_reg      <= 5'd1;
            mc_reg        <= '0;
            qsel_reg      <= Q1;
            out_valid_reg <= 1'b0;
            for (int q = 0; q < NUM_Q; q++)
            begin
                head_reg[q]  <= '0;
                count_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_QUANTUM1: q1_reg     <= cfg_data;
                    CFG_QUANTUM2: q2_reg     <= cfg_data;
                    CFG_QUANTUM3: q3_reg     <= cfg_data;
                    CFG_PERIOD:   period_reg <= cfg_data[7:0];
                    default:      period_reg <= period_reg;
                endcase
            end

            if (mem_we)
            begin
                count_reg[push_q] <= count_reg[push_q] + 5'd1;
            end
            if (pop_en)
            begin
                head_reg[pop_q]  <= head_reg[pop_q] + 4'd1;
                count_reg[pop_q] <= count_reg[pop_q] - 5'd1;
            end

            // S_OUT loads the next result itself
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        qsel_reg <= Q1;
                        if (req.item.req_type == REQ_JOIN && has_reg
                            && done_reg[req.item.target_id])
                        begin
                            done_reg[req.item.target_id] <= 1'b0;
                        end
                    end
                end
                S_CR_CUR:
                begin
                    cur_reg  <= nfid_reg[ID_W-1:0];
                    has_reg  <= 1'b1;
                    nfid_reg <= nfid_reg + 5'd1;
                end
                S_CR_NEW:
                begin
                    nfid_reg <= nfid_reg + 5'd1;
                end
                S_SC_START:
                begin
                    n_reg <= count_reg[qsel_reg];
                    i_reg <= '0;
                    if (count_reg[qsel_reg] == '0)
                    begin
                        if (qsel_reg == Q3)
                        begin
                            mc_reg <= mc_reg + 8'd1;
                        end
                        else
                        begin
                            qsel_reg <= qsel_reg + 2'd1;
                        end
                    end
                end
                S_SC_EVAL:
                begin
                    if (eval_pick)
                    begin
                        next_reg <= rd_reg;
                        if (st_rd == ST_WAIT_T)
                        begin
                            done_reg[w_t] <= 1'b0;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + 5'd1;
                        if (last_in_q)
                        begin
                            if (qsel_reg == Q3)
                            begin
                                mc_reg <= mc_reg + 8'd1;
                            end
                            else
                            begin
                                qsel_reg <= qsel_reg + 2'd1;
                            end
                        end
                    end
                end
                S_APPLY:
                begin
                    if (st_cur == ST_EXIT)
                    begin
                        done_reg[cur_reg] <= 1'b1;
                    end
                end
                S_MAINT:
                begin
                    mc_reg <= (mc_reg < period_reg) ? mc_reg + 8'd1 : 8'd0;
                end
                S_FINISH:
                begin
                    cur_reg <= next_reg;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default: qsel_reg <= qsel_reg;
            endcase
        end
    end

    // thread tables and result fields, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_reg <= '0;
                    if (req.item.req_type == REQ_CREATE)
                    begin
                        res_reg.running_id <= has_reg ? cur_reg : '0;
                        res_reg.error      <= cr_err;
                    end
                    else if (has_reg)
                    begin
                        res_reg.running_id <= cur_reg;
                        case (req.item.req_type)
                            REQ_YIELD:
                            begin
                                if (st_cur == ST_RUN)
                                begin
                                    status_reg[cur_reg] <= ST_YIELD;
                                end
                            end
                            REQ_EXIT: status_reg[cur_reg] <= ST_EXIT;
                            REQ_JOIN:
                            begin
                                if (done_reg[req.item.target_id])
                                begin
                                    res_reg.join_done <= 1'b1;
                                end
                                else
                                begin
                                    wait_reg[cur_reg]   <= req.item.target_id;
                                    status_reg[cur_reg] <= ST_WAIT_T;
                                end
                            end
                            default: res_reg.join_done <= 1'b0;
                        endcase
                    end
                end
            end
            S_CR_CUR, S_CR_NEW:
            begin
                status_reg[nfid_reg[ID_W-1:0]] <= ST_RUN;
                level_reg[nfid_reg[ID_W-1:0]]  <= 2'd1;
                wait_reg[nfid_reg[ID_W-1:0]]   <= '0;
                if (state_reg == S_CR_NEW)
                begin
                    res_reg.new_id <= nfid_reg[ID_W-1:0];
                end
            end
            S_CR_MARK:
            begin
                if (st_cur == ST_RUN)
                begin
                    status_reg[cur_reg] <= ST_YIELD;
                end
                res_reg.running_id <= cur_reg;
            end
            S_SC_EVAL:
            begin
                if (eval_pick && st_rd == ST_WAIT_T)
                begin
                    status_reg[rd_reg] <= ST_RUN;
                end
            end
            S_APPLY:
            begin
                case (st_cur)
                    ST_RUN:   level_reg[cur_reg]  <= (lv_rd == 2'd1) ? 2'd2 : 2'd3;
                    ST_YIELD: status_reg[cur_reg] <= ST_RUN;
                    default:  res_reg.switched    <= 1'b0;
                endcase
            end
            S_PROMOTE:
            begin
                level_reg[rd_reg] <= 2'd1;
            end
            S_FINISH:
            begin
                res_reg.running_id <= next_reg;
                res_reg.switched   <= 1'b1;
                case (lv_rd)
                    2'd1:    res_reg.quantum <= q1_reg;
                    2'd2:    res_reg.quantum <= q2_reg;
                    default: res_reg.quantum <= q3_reg;
                endcase
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_reg <= res_reg;
                end
            end
            default: res_reg <= res_reg;
        endcase
    end

endmodule

/* hw/rtl/mlfq_thread_scheduler.sv */
// Top level of the three-level feedback-queue thread scheduler.
//
// Scheduling events enter on in_valid/in_stall with in_item carrying the
// request kind and join target; an item is taken when in_valid is high and
// in_stall low. Up to two items wait in a front queue while the sequencer
// works on the current one, so the sender stalls only when that queue fills.
// Each item gives exactly one result on out_valid/out_stall in out_item.
// An item that causes no scheduling pass goes straight to its result; a pass
// reads and evaluates each ready-queue entry it inspects, steps past each
// empty or exhausted queue and may promote one thread, and a create first
// sets up its new thread and, with none running, the first one; at most 15
// threads exist. The sequencer pops and pushes the ready queues through one
// memory that has a separate write port and read port. A result waits in the
// output register while out_stall is high and the sequencer holds the next
// result until that register is free.
// Configuration writes go over cfg_valid/cfg_ready with cfg_index/cfg_data;
// cfg_ready is always high and a write takes effect at once, so the user must
// make writes only while no item is in flight; the block does not enforce it.
// Reset clears the queue pointers, done map, current thread and counters and
// restores the default time slices; no clearing pass is needed.
module mlfq_thread_scheduler import mlfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    req_ch_t req;
    logic    req_pop;

    assign cfg_ready = 1'b1;

    mlfq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .req      (req),
        .req_pop  (req_pop)
    );

    mlfq_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_pop   (req_pop),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

/* hw/rtl/mlfq_checker.sv */
// Port-level checks for the scheduler, bound to the top level.
module mlfq_assertions import mlfq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input out_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_err_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.error |-> !out_item.switched && out_item.new_id == 4'd0)
        else $error("error result reports a switch or new thread");

    a_quantum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.switched |-> out_item.quantum == 16'd0)
        else $error("slice given without a switch");

    a_join_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.join_done |-> !out_item.switched)
        else $error("reaped join also switched");

endmodule

bind mlfq_thread_scheduler mlfq_assertions u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

/* verif/mlfq_checker.sv */
// Checker for the feedback-queue scheduler: mirrors its state, predicts each result and compares.
module mlfq_checker import mlfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_t         in_item,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_t        out_item,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    logic [15:0] slice1, slice2, slice3;
    logic [7:0]  period;

    logic [3:0]  rq      [3][MAX_THREADS];
    logic [3:0]  rq_head [3];
    logic [4:0]  rq_cnt  [3];
    logic [2:0]  status  [MAX_THREADS];
    logic [1:0]  level   [MAX_THREADS];
    logic [3:0]  joinee  [MAX_THREADS];
    logic        finished[MAX_THREADS];
    logic [3:0]  cur;
    logic        have_cur;
    logic [4:0]  free_id;
    logic [7:0]  sw_count;

    out_t due_results[$];

    assign pending = due_results.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("checker: %s got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic void rq_push(input int q, input logic [3:0] id);
        if (rq_cnt[q] < MAX_THREADS)
        begin
            rq[q][4'(rq_head[q] + rq_cnt[q])] = id;
            rq_cnt[q]++;
        end
    endfunction

    function automatic logic [3:0] rq_pop(input int q);
        logic [3:0] id;
        id = rq[q][rq_head[q]];
        rq_head[q] = rq_head[q] + 1;
        rq_cnt[q]--;
        return id;
    endfunction

    // one rotation through a queue: blocked joiners go to the back
    function automatic bit pick(input int q, output logic [3:0] chosen);
        int n;
        logic [3:0] t;
        logic [3:0] w;
        n = rq_cnt[q];
        chosen = '0;
        for (int i = 0; i < n; i++)
        begin
            t = rq_pop(q);
            if (status[t] == ST_RUN || status[t] == ST_WAIT_M)
            begin
                chosen = t;
                return 1;
            end
            if (status[t] == ST_WAIT_T)
            begin
                w = joinee[t];
                if (finished[w])
                begin
                    finished[w] = 0;
                    status[t] = ST_RUN;
                    chosen = t;
                    return 1;
                end
                rq_push(q, t);
            end
        end
        return 0;
    endfunction

    function automatic void requeue(input logic [3:0] t);
        rq_push(level_queue(level[t]), t);
    endfunction

    function automatic void switch_thread(inout out_t r);
        logic [3:0] nxt;
        logic [3:0] m;
        logic [1:0] lv;
        if (!pick(0, nxt) && !pick(1, nxt) && !pick(2, nxt))
        begin
            sw_count++;
            return;
        end
        case (status[cur])
            ST_RUN:
            begin
                if (level[cur] == 2'd1)
                begin
                    level[cur] = 2'd2;
                    rq_push(1, cur);
                end
                else
                begin
                    level[cur] = 2'd3;
                    rq_push(2, cur);
                end
            end
            ST_YIELD:
            begin
                status[cur] = ST_RUN;
                requeue(cur);
            end
            ST_WAIT_M, ST_WAIT_T: requeue(cur);
            ST_EXIT: finished[cur] = 1;
            default: ;
        endcase
        if (sw_count < period)
            sw_count++;
        else
        begin
            if (rq_cnt[2] != 0)
            begin
                m = rq_pop(2);
                level[m] = 2'd1;
                rq_push(0, m);
            end
            else if (rq_cnt[1] != 0)
            begin
                m = rq_pop(1);
                level[m] = 2'd1;
                rq_push(0, m);
            end
            sw_count = '0;
        end
        cur = nxt;
        lv = level[nxt];
        r.running_id = nxt;
        r.quantum = (lv == 2'd1) ? slice1 : (lv == 2'd2) ? slice2 : slice3;
        r.switched = 1'b1;
    endfunction

    function automatic void new_thread(input logic [3:0] t);
        status[t] = ST_RUN;
        level[t] = 2'd1;
        joinee[t] = '0;
    endfunction

    function automatic out_t predict_event(input in_t ev);
        out_t r;
        logic [3:0] nid;
        r = '0;
        if (ev.req_type == REQ_CREATE)
        begin
            if (free_id + (have_cur ? 1 : 2) > MAX_THREADS || rq_cnt[0] >= MAX_THREADS)
            begin
                r.running_id = have_cur ? cur : 4'd0;
                r.error = 1'b1;
                return r;
            end
            if (!have_cur)
            begin
                cur = free_id[3:0];
                free_id++;
                new_thread(cur);
                have_cur = 1;
            end
            nid = free_id[3:0];
            free_id++;
            new_thread(nid);
            rq_push(0, nid);
            r.new_id = nid;
            if (status[cur] == ST_RUN)
                status[cur] = ST_YIELD;
            r.running_id = cur;
            switch_thread(r);
            return r;
        end
        if (!have_cur)
            return r;
        r.running_id = cur;
        case (ev.req_type)
            REQ_TIMER: switch_thread(r);
            REQ_YIELD:
            begin
                if (status[cur] == ST_RUN)
                    status[cur] = ST_YIELD;
                switch_thread(r);
            end
            REQ_EXIT:
            begin
                status[cur] = ST_EXIT;
                switch_thread(r);
            end
            REQ_JOIN:
            begin
                if (finished[ev.target_id])
                begin
                    finished[ev.target_id] = 0;
                    r.join_done = 1'b1;
                end
                else
                begin
                    joinee[cur] = ev.target_id;
                    status[cur] = ST_WAIT_T;
                    switch_thread(r);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            slice1 <= 16'd10;
            slice2 <= 16'd20;
            slice3 <= 16'd40;
            period <= 8'd10;
            for (int q = 0; q < 3; q++)
            begin
                rq_head[q] = '0;
                rq_cnt[q] = '0;
            end
            for (int t = 0; t < MAX_THREADS; t++)
            begin
                finished[t] = 0;
                status[t] = ST_RUN;
                level[t] = 2'd1;
                joinee[t] = '0;
            end
            cur = '0;
            have_cur = 0;
            free_id = 5'd1;
            sw_count = '0;
            fail_count = 0;
            due_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_QUANTUM1: slice1 <= cfg_data;
                    CFG_QUANTUM2: slice2 <= cfg_data;
                    CFG_QUANTUM3: slice3 <= cfg_data;
                    CFG_PERIOD:   period <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                due_results.push_back(predict_event(in_item));
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    report("unexpected result, running_id", out_item.running_id, 0);
                else
                begin
                    want = due_results.pop_front();
                    if (out_item.running_id !== want.running_id)
                        report("running_id", out_item.running_id, want.running_id);
                    if (out_item.quantum !== want.quantum)
                        report("quantum", out_item.quantum, want.quantum);
                    if (out_item.new_id !== want.new_id)
                        report("new_id", out_item.new_id, want.new_id);
                    if (out_item.join_done !== want.join_done)
                        report("join_done", out_item.join_done, want.join_done);
                    if (out_item.switched !== want.switched)
                        report("switched", out_item.switched, want.switched);
                    if (out_item.error !== want.error)
                        report("error", out_item.error, want.error);
                end
            end
        end
    end

endmodule

/* verif/tb_top.sv */
// Testbench top: clock, reset, stimulus and configuration for the scheduler, and the verdict.
module tb_top;
    import mlfq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_item;
    logic        out_valid;
    logic        out_stall;
    out_t        out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle = 0;
    bit          long_hold;

    localparam int CYCLE_LIMIT = 900000;

    mlfq_thread_scheduler u_top (.*);

    mlfq_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls on its own pattern, with one long hold-off on request
    initial
    begin
        int mode;
        bit held;
        held = 0;
        out_stall <= 0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold && !held)
            begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                out_stall <= 0;
                held = 1;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(10, 60))
            begin
                @(posedge clk);
                out_stall <= (mode == 0) ? 1'b0 :
                             (mode == 1) ? ($urandom_range(0, 3) == 0) :
                             (mode == 2) ? ($urandom_range(0, 1) == 1) :
                                           ($urandom_range(0, 5) != 0);
            end
        end
    end

    task automatic send_event(input logic [2:0] kind, input logic [3:0] tgt);
        in_valid <= 1;
        in_item <= '{req_type: kind, target_id: tgt};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle_gap();
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic burst(input int n, input int create_weight);
        logic [2:0] kind;
        int r;
        int len;
        while (n > 0)
        begin
            len = $urandom_range(1, 20);
            while (len > 0 && n > 0)
            begin
                r = $urandom_range(0, 99);
                if (r < create_weight) kind = REQ_CREATE;
                else if (r < 40) kind = REQ_TIMER;
                else if (r < 58) kind = REQ_YIELD;
                else if (r < 72) kind = REQ_EXIT;
                else if (r < 95) kind = REQ_JOIN;
                else kind = 3'($urandom_range(5, 7));
                send_event(kind, 4'($urandom));
                len--;
                n--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap();
        end
        in_valid <= 0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic settings(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c, input logic [7:0] p);
        write_reg(CFG_QUANTUM1, a);
        write_reg(CFG_QUANTUM2, b);
        write_reg(CFG_QUANTUM3, c);
        write_reg(CFG_PERIOD, {8'd0, p});
    endtask

    initial
    begin
        in_valid = 0;
        in_item = '0;
        cfg_valid = 0;
        cfg_index = CFG_QUANTUM1;
        cfg_data = '0;
        long_hold = 0;
        @(posedge rst_n);
        @(posedge clk);

        // with no thread yet, everything but create is a no-op
        send_event(REQ_TIMER, 4'd0);
        send_event(REQ_JOIN, 4'd15);
        send_event(3'd7, 4'd0);
        send_event(REQ_CREATE, 4'd0);
        send_event(REQ_CREATE, 4'd9);
        send_event(REQ_JOIN, 4'd1);
        send_event(REQ_EXIT, 4'd0);
        send_event(REQ_JOIN, 4'd2);
        send_event(REQ_TIMER, 4'd0);
        send_event(REQ_YIELD, 4'd0);
        send_event(3'd5, 4'd3);
        send_event(3'd6, 4'd0);
        send_event(REQ_JOIN, 4'd0);
        // run out of identifiers
        repeat (12) send_event(REQ_CREATE, 4'd0);
        in_valid <= 0;
        drain();

        settings(16'd1, 16'd65535, 16'd1, 8'd0);
        long_hold = 1;
        burst(200, 6);
        drain();

        settings(16'd65535, 16'd1, 16'd65535, 8'd255);
        burst(300, 6);
        drain();

        settings(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom_range(1, 4)));
        burst(500, 6);
        drain();

        settings(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        burst(525, 6);
        drain();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
